// ===== rtl/bia_pkg.sv =====
// Shared widths, command codes and default sizes for the bitmap identifier allocator.
package bia_pkg;

    localparam int HINT_W   = 13;   // search hint register width
    localparam int ID_OUT_W = 12;   // identifier field width on the channels

    localparam int WORD_BITS_DEF  = 32;
    localparam int WORD_COUNT_DEF = 128;
    localparam int LOWEST_ID_DEF  = 300;
    localparam int HIGHEST_ID_DEF = 4095;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

endpackage

// ===== rtl/bia_req_if.sv =====
// Request channel: command and identifier to release.
interface bia_req_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [bia_pkg::ID_OUT_W-1:0]  release_id;

    modport source (output valid, output command, output release_id, input ready);
    modport sink   (input valid, input command, input release_id, output ready);
endinterface

// ===== rtl/bia_rsp_if.sv =====
// Response channel: granted or echoed identifier and success flag.
interface bia_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bia_pkg::ID_OUT_W-1:0]  granted_id;
    logic                          success;

    modport source (output valid, output granted_id, output success, input ready);
    modport sink   (input valid, input granted_id, input success, output ready);
endinterface

// ===== rtl/bitmap_id_allocator.sv =====
// Top level of the bitmap identifier allocator: sequencer, hint, scan and output register.
//
//  channel | dir | words carried                      | handshake
//  --------+-----+------------------------------------+-----------------------------
//  req     | in  | command, release_id                | valid/ready, taken in IDLE
//  rsp     | out | granted_id, success                | valid/ready, output register
//
// Steps: a hint hit or a release passes accept, reciprocal multiply, word/bit
//   split with RAM read and read-modify-write. A rejected item (hint or
//   release id out of range) finishes in the accept cycle. A hint miss adds a
//   scan over the words and over the bits of words with a free count,
//   all on the single read port of the bitmap and count RAMs.
// Reset: a clearing pass writes every word to zero and its free count to its
//   initial value; no word is taken meanwhile.
// Stalls: the result sits in the output register; the next word is taken while
//   it waits, and an item that finishes against a full register holds in OUT.
module bitmap_id_allocator #(
    parameter int WORD_BITS  = bia_pkg::WORD_BITS_DEF,
    parameter int WORD_COUNT = bia_pkg::WORD_COUNT_DEF,
    parameter int LOWEST_ID  = bia_pkg::LOWEST_ID_DEF,
    parameter int HIGHEST_ID = bia_pkg::HIGHEST_ID_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bia_req_if.sink     req,
    bia_rsp_if.source   rsp
);

    localparam int HINT_W = bia_pkg::HINT_W;
    localparam int OUT_W  = bia_pkg::ID_OUT_W;
    localparam int FC_W   = $clog2(WORD_BITS + 1);   // free count
    localparam int BW     = $clog2(WORD_BITS);       // bit index
    localparam int WA     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int TOTAL  = WORD_BITS * WORD_COUNT;
    localparam int ID_W   = $clog2(TOTAL + 1);
    localparam int VW     = (ID_W > HINT_W) ? ID_W : HINT_W;  // compare width
    localparam int EW     = VW + 1;
    localparam int HI_EFF = (HIGHEST_ID < TOTAL - 1) ? HIGHEST_ID : TOTAL - 1;
    // x / WORD_BITS as (x * MAGIC) >> DIV_S, exact for all 13-bit x
    localparam int DIV_S  = HINT_W + 7;
    localparam int MAGIC  = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;
    localparam int M_W    = $clog2(MAGIC + 1);
    localparam int P_W    = HINT_W + M_W;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_DIV1  = 8'b0000_0100,
        ST_DIV2  = 8'b0000_1000,
        ST_CHK   = 8'b0001_0000,
        ST_SWORD = 8'b0010_0000,
        ST_SBIT  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    function automatic logic id_ok(input logic [VW-1:0] v);
        return (v >= VW'(LOWEST_ID)) && (v <= VW'(HIGHEST_ID)) && (v < VW'(TOTAL));
    endfunction

    // valid identifiers in the word starting at base
    function automatic logic [FC_W-1:0] init_count(input logic [ID_W-1:0] base);
        logic [EW-1:0] s;
        logic [EW-1:0] e;
        logic [EW-1:0] lo;
        logic [EW-1:0] hi;
        s  = EW'(base);
        e  = s + EW'(WORD_BITS - 1);
        lo = (s > EW'(LOWEST_ID)) ? s : EW'(LOWEST_ID);
        hi = (e < EW'(HI_EFF)) ? e : EW'(HI_EFF);
        if (lo > hi)
        begin
            return '0;
        end
        return FC_W'(hi - lo + EW'(1));
    endfunction

    state_t               state_reg,   state_next;
    logic [HINT_W-1:0]    hint_reg,    hint_next;
    logic [WA-1:0]        w_reg,       w_next;      // word index / clear counter
    logic [ID_W-1:0]      base_reg,    base_next;   // first id of word w_reg
    logic [ID_W-1:0]      id_reg,      id_next;     // id under the bit scan
    logic [BW-1:0]        bit_reg,     bit_next;
    logic [BW-1:0]        r_reg,       r_next;      // bit of x within its word
    logic [HINT_W-1:0]    x_reg,       x_next;      // hint or released id
    logic [HINT_W-1:0]    q_reg,       q_next;      // word of x
    logic                 cmd_reg,     cmd_next;
    logic [OUT_W-1:0]     res_id_reg,  res_id_next;
    logic                 res_ok_reg,  res_ok_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_id_reg,  out_id_next;
    logic                 out_ok_reg,  out_ok_next;

    // RAM ports
    logic                 wr_en;
    logic [WA-1:0]        rd_addr;
    logic                 rd_en;
    logic [WORD_BITS-1:0] used_wr, used_rd;
    logic [FC_W-1:0]      free_wr, free_rd;

    logic                 fin;
    logic [OUT_W-1:0]     fin_id;
    logic                 fin_ok;
    logic                 slot_free;
    logic [P_W-1:0]       prod;
    logic [VW-1:0]        qwb;
    logic [WORD_BITS-1:0] one_hot;
    logic [WORD_BITS-1:0] mask_r;
    logic                 last_word;

    bia_ram #(.WIDTH(WORD_BITS), .DEPTH(WORD_COUNT)) u_used_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (w_reg),
        .wr_data (used_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (used_rd)
    );

    bia_ram #(.WIDTH(FC_W), .DEPTH(WORD_COUNT)) u_free_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (w_reg),
        .wr_data (free_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (free_rd)
    );

    assign slot_free = !out_valid_reg || rsp.ready;
    assign prod      = P_W'(x_reg) * P_W'(MAGIC);
    assign qwb       = VW'(q_reg) * VW'(WORD_BITS);
    assign one_hot   = {{(WORD_BITS - 1){1'b0}}, 1'b1} << bit_reg;
    assign mask_r    = {{(WORD_BITS - 1){1'b0}}, 1'b1} << r_reg;
    assign last_word = (w_reg == WA'(WORD_COUNT - 1));

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.granted_id = out_id_reg;
    assign rsp.success    = out_ok_reg;

    always_comb
    begin
        state_next  = state_reg;
        hint_next   = hint_reg;
        w_next      = w_reg;
        base_next   = base_reg;
        id_next     = id_reg;
        bit_next    = bit_reg;
        r_next      = r_reg;
        x_next      = x_reg;
        q_next      = q_reg;
        cmd_next    = cmd_reg;
        res_id_next = res_id_reg;
        res_ok_next = res_ok_reg;
        wr_en       = 1'b0;
        used_wr     = used_rd;
        free_wr     = free_rd;
        rd_en       = 1'b0;
        rd_addr     = w_reg;
        fin         = 1'b0;
        fin_id      = '0;
        fin_ok      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                used_wr = '0;
                free_wr = init_count(base_reg);
                if (last_word)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    w_next    = w_reg + WA'(1);
                    base_next = base_reg + ID_W'(WORD_BITS);
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next = req.command;
                    if (req.command == bia_pkg::CMD_ALLOC)
                    begin
                        x_next = hint_reg;
                        if (!id_ok(VW'(hint_reg)))
                        begin
                            fin = 1'b1;   // hint past the range
                        end
                        else
                        begin
                            state_next = ST_DIV1;
                        end
                    end
                    else
                    begin
                        x_next = HINT_W'(req.release_id);
                        if (!id_ok(VW'(req.release_id)))
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            state_next = ST_DIV1;
                        end
                    end
                end
            end

            ST_DIV1:
            begin
                q_next     = HINT_W'(prod >> DIV_S);
                state_next = ST_DIV2;
            end

            ST_DIV2:
            begin
                r_next     = BW'(VW'(x_reg) - qwb);
                base_next  = ID_W'(qwb);
                w_next     = WA'(q_reg);
                rd_en      = 1'b1;
                rd_addr    = WA'(q_reg);
                state_next = ST_CHK;
            end

            ST_CHK:
            begin
                if (cmd_reg == bia_pkg::CMD_RELEASE)
                begin
                    if (used_rd[r_reg])
                    begin
                        wr_en   = 1'b1;
                        used_wr = used_rd & ~mask_r;
                        free_wr = (free_rd < FC_W'(WORD_BITS)) ? free_rd + FC_W'(1) : free_rd;
                        if (hint_reg > x_reg)
                        begin
                            hint_next = x_reg;
                        end
                        fin_id = OUT_W'(x_reg);
                        fin_ok = 1'b1;
                    end
                    fin = 1'b1;
                end
                else if (!used_rd[r_reg])
                begin
                    // hint hit
                    wr_en     = 1'b1;
                    used_wr   = used_rd | mask_r;
                    free_wr   = (free_rd != '0) ? free_rd - FC_W'(1) : free_rd;
                    hint_next = x_reg + HINT_W'(1);
                    fin       = 1'b1;
                    fin_id    = OUT_W'(x_reg);
                    fin_ok    = 1'b1;
                end
                else
                begin
                    // scan starts at the hint's own word; its data is already read
                    state_next = ST_SWORD;
                end
            end

            ST_SWORD:
            begin
                if (free_rd == '0)
                begin
                    if (last_word)
                    begin
                        fin = 1'b1;   // nothing free
                    end
                    else
                    begin
                        w_next    = w_reg + WA'(1);
                        base_next = base_reg + ID_W'(WORD_BITS);
                        rd_en     = 1'b1;
                        rd_addr   = w_reg + WA'(1);
                    end
                end
                else
                begin
                    bit_next   = '0;
                    id_next    = base_reg;
                    state_next = ST_SBIT;
                end
            end

            ST_SBIT:
            begin
                if (id_ok(VW'(id_reg)) && !used_rd[bit_reg])
                begin
                    wr_en     = 1'b1;
                    used_wr   = used_rd | one_hot;
                    free_wr   = (free_rd != '0) ? free_rd - FC_W'(1) : free_rd;
                    hint_next = HINT_W'(id_reg) + HINT_W'(1);
                    fin       = 1'b1;
                    fin_id    = OUT_W'(id_reg);
                    fin_ok    = 1'b1;
                end
                else if (bit_reg == BW'(WORD_BITS - 1))
                begin
                    if (last_word)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        w_next     = w_reg + WA'(1);
                        base_next  = base_reg + ID_W'(WORD_BITS);
                        rd_en      = 1'b1;
                        rd_addr    = w_reg + WA'(1);
                        state_next = ST_SWORD;
                    end
                end
                else
                begin
                    bit_next = bit_reg + BW'(1);
                    id_next  = id_reg + ID_W'(1);
                end
            end

            ST_OUT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            res_id_next = fin_id;
            res_ok_next = fin_ok;
            state_next  = slot_free ? ST_IDLE : ST_OUT;
        end
    end

    // output register: fed at finish time, or from the held result in OUT
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_id_next    = out_id_reg;
        out_ok_next    = out_ok_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (fin && slot_free)
        begin
            out_valid_next = 1'b1;
            out_id_next    = fin_id;
            out_ok_next    = fin_ok;
        end
        else if ((state_reg == ST_OUT) && slot_free)
        begin
            out_valid_next = 1'b1;
            out_id_next    = res_id_reg;
            out_ok_next    = res_ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            hint_reg      <= HINT_W'(LOWEST_ID);
            w_reg         <= '0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            w_reg         <= w_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        bit_reg    <= bit_next;
        r_reg      <= r_next;
        x_reg      <= x_next;
        q_reg      <= q_next;
        cmd_reg    <= cmd_next;
        res_id_reg <= res_id_next;
        res_ok_reg <= res_ok_next;
        out_id_reg <= out_id_next;
        out_ok_reg <= out_ok_next;
    end

`ifndef SYNTHESIS
    // a failed word always carries identifier zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.success) |-> (rsp.granted_id == '0))
        else $error("failed response with nonzero identifier");

    // a successful response names an identifier inside the valid range
    a_grant_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.success) |->
        ((VW'(rsp.granted_id) >= VW'(LOWEST_ID)) && (VW'(rsp.granted_id) <= VW'(HI_EFF))))
        else $error("response identifier outside the valid range");

    // hint never drops below the lowest identifier
    a_hint_floor: assert property (@(posedge clk) disable iff (!rst_n)
        hint_reg >= HINT_W'(LOWEST_ID))
        else $error("search hint below lowest identifier");

    // no word is taken while the clearing pass runs
    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !($past(req.valid) && $past(req.ready)))
        else $error("request accepted during clearing pass");
`endif

endmodule

// ===== rtl/bia_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
module bia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
